/* hdl/sab_pkg.sv */
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants of the suffix automaton builder
// Node table geometry, item kinds, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package sab_pkg;
  localparam int MAX_TEXT = 1024;
  localparam int ALPHABET = 26;
  localparam int NODE_CAP = 2 * MAX_TEXT;
  localparam int NW       = $clog2(NODE_CAP);      // node index bits
  localparam int SW       = 5;                      // symbol bits
  localparam int LW       = $clog2(MAX_TEXT + 1);  // length bits
  localparam int PW       = NW + 1;                 // signed link bits
  localparam int TDEPTH   = NODE_CAP * ALPHABET;
  localparam int TAW      = $clog2(TDEPTH);

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [PW-1:0] NONE = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_ROOT,
    S_AP_LEN, S_AP_LEN_W, S_AP_INIT,
    S_W_RD, S_W_WAIT, S_W_CHK,
    S_Q_RD, S_Q_WAIT, S_Q_CHK,
    S_CL_RD, S_CL_WAIT, S_CL_WR, S_CL_LNK,
    S_R_RD, S_R_WAIT, S_R_CHK,
    S_FIN, S_OUT
  } state_t;
endpackage
`default_nettype wire

/* hdl/sab_ram.sv */
// ----------------------------------------------------------------------------
// sab_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/suffix_automaton_builder.sv */
// ----------------------------------------------------------------------------
// suffix_automaton_builder: online suffix automaton construction
// Node lengths, links and transitions sit in three single-port RAMs driven by
// one sequencer; each append walks suffix links and may clone a node.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)                    | tuser
// in_     | in  | symbol[4:0] node[15:5]                          | kind[1:0]
// out_    | out | status node_count longest new_node cloned       | -
//         |     | entry_length entry_link entry_next (72 bits)    |
// An append fills the new node's transitions, walks suffix links and, when it
// clones, copies the transitions one at a time through the single transition RAM
// port. Not ready while an item runs; the result register frees the block
// once taken. Reset (sync, active low) writes the root entry first.
// ----------------------------------------------------------------------------
`default_nettype none
module suffix_automaton_builder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // symbol, node
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // status, node_count, longest, new_node,
                                       // cloned, entry_length, entry_link,
                                       // entry_next
);
  localparam int NW = sab_pkg::NW;
  localparam int LW = sab_pkg::LW;
  localparam int PW = sab_pkg::PW;
  localparam int SW = sab_pkg::SW;
  localparam int TAW = sab_pkg::TAW;
  localparam int AW = $clog2(sab_pkg::ALPHABET);

  sab_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] last_r, last_nxt, high_r, high_nxt;
  logic [LW-1:0] long_r, long_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [SW-1:0] sym_r, sym_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [NW-1:0] now_r, now_nxt, q_r, q_nxt, ne_r, ne_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [PW-1:0] cv_r, cv_nxt;
  logic          cl_r, cl_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [LW-1:0] elen_r, elen_nxt;
  logic [PW-1:0] elink_r, elink_nxt, enext_r, enext_nxt;
  logic          ov_r, ov_nxt;

  logic          len_we, lnk_we, tr_we;
  logic [NW-1:0] len_a, lnk_a;
  logic [TAW-1:0] tr_a;
  logic [LW-1:0] len_wd, len_rd;
  logic [PW-1:0] lnk_wd, lnk_rd, tr_wd, tr_rd;

  sab_ram #(.WIDTH(LW), .DEPTH(sab_pkg::NODE_CAP)) u_len (
    .clk(clk), .we(len_we), .addr(len_a), .wdata(len_wd), .rdata(len_rd));
  sab_ram #(.WIDTH(PW), .DEPTH(sab_pkg::NODE_CAP)) u_lnk (
    .clk(clk), .we(lnk_we), .addr(lnk_a), .wdata(lnk_wd), .rdata(lnk_rd));
  sab_ram #(.WIDTH(PW), .DEPTH(sab_pkg::TDEPTH)) u_tr (
    .clk(clk), .we(tr_we), .addr(tr_a), .wdata(tr_wd), .rdata(tr_rd));

  function automatic logic [TAW-1:0] slot(input logic [NW-1:0] n,
                                         input logic [SW-1:0] c);
    slot = TAW'(n * sab_pkg::ALPHABET) + TAW'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sab_pkg::S_ROOT;
      last_r  <= '0;
      high_r  <= '0;
      long_r  <= '0;
      k_r     <= '0;
      ov_r    <= 1'b0;
      kind_r  <= sab_pkg::KIND_APPEND;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      high_r  <= high_nxt;
      long_r  <= long_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
      kind_r  <= kind_nxt;
    end
    sym_r <= sym_nxt;   node_r <= node_nxt; now_r <= now_nxt;
    q_r <= q_nxt;       ne_r <= ne_nxt;     p_r <= p_nxt;
    plen_r <= plen_nxt; cv_r <= cv_nxt;
    cl_r <= cl_nxt;     st_r <= st_nxt;     elen_r <= elen_nxt;
    elink_r <= elink_nxt; enext_r <= enext_nxt;
  end

  assign in_tready  = (state_r == sab_pkg::S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {enext_r, elink_r, elen_r, cl_r, now_r, long_r,
                       {1'b0, high_r} + 12'd1, st_r};

  always_comb begin
    state_nxt = state_r; last_nxt = last_r; high_nxt = high_r; long_nxt = long_r;
    kind_nxt = kind_r; sym_nxt = sym_r; node_nxt = node_r; now_nxt = now_r;
    q_nxt = q_r; ne_nxt = ne_r; p_nxt = p_r; plen_nxt = plen_r;
    k_nxt = k_r; cv_nxt = cv_r; cl_nxt = cl_r; st_nxt = st_r;
    elen_nxt = elen_r; elink_nxt = elink_r; enext_nxt = enext_r; ov_nxt = ov_r;
    len_we = 1'b0; lnk_we = 1'b0; tr_we = 1'b0;
    len_a = '0; lnk_a = '0; tr_a = '0;
    len_wd = '0; lnk_wd = '0; tr_wd = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      sab_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          kind_nxt = in_tuser; sym_nxt = in_tdata[SW-1:0];
          node_nxt = in_tdata[SW+NW-1:SW];
          st_nxt = sab_pkg::ST_OK; now_nxt = '0; cl_nxt = 1'b0;
          elen_nxt = '0; elink_nxt = '0; enext_nxt = '0; k_nxt = '0;
          unique case (in_tuser)
            sab_pkg::KIND_APPEND: begin
              if (in_tdata[SW-1:0] >= SW'(sab_pkg::ALPHABET)) begin
                st_nxt = sab_pkg::ST_RANGE; state_nxt = sab_pkg::S_OUT;
              end else if (long_r >= LW'(sab_pkg::MAX_TEXT) ||
                           {1'b0, high_r} + (NW+1)'(2) >=
                           (NW+1)'(sab_pkg::NODE_CAP)) begin
                st_nxt = sab_pkg::ST_FULL; state_nxt = sab_pkg::S_OUT;
              end else state_nxt = sab_pkg::S_AP_LEN;
            end
            sab_pkg::KIND_READ: begin
              if (in_tdata[SW+NW-1:SW] > high_r) begin
                st_nxt = sab_pkg::ST_RANGE; elink_nxt = sab_pkg::NONE;
                enext_nxt = sab_pkg::NONE; state_nxt = sab_pkg::S_OUT;
              end else state_nxt = sab_pkg::S_RD_A;
            end
            sab_pkg::KIND_CLEAR: state_nxt = sab_pkg::S_ROOT;
            default: state_nxt = sab_pkg::S_OUT;
          endcase
        end
      end
      sab_pkg::S_RD_A: begin
        len_a = node_r; lnk_a = node_r; tr_a = slot(node_r, sym_r);
        state_nxt = sab_pkg::S_RD_B;
      end
      sab_pkg::S_RD_B: begin
        elen_nxt = len_rd; elink_nxt = lnk_rd;
        enext_nxt = (sym_r < SW'(sab_pkg::ALPHABET)) ? tr_rd : sab_pkg::NONE;
        state_nxt = sab_pkg::S_OUT;
      end
      sab_pkg::S_ROOT: begin
        // write root entry, one transition per cycle
        last_nxt = '0; high_nxt = '0; long_nxt = '0;
        len_we = 1'b1; len_a = '0; len_wd = '0;
        lnk_we = 1'b1; lnk_a = '0; lnk_wd = sab_pkg::NONE;
        tr_we = 1'b1; tr_a = TAW'(k_r); tr_wd = sab_pkg::NONE;
        k_nxt = k_r + 1'b1;
        if (k_r == AW'(sab_pkg::ALPHABET - 1)) begin
          k_nxt = '0;
          // a clear word answers, the pass after reset does not
          state_nxt = (kind_r == sab_pkg::KIND_CLEAR) ? sab_pkg::S_OUT
                                                      : sab_pkg::S_IDLE;
        end
      end
      sab_pkg::S_AP_LEN: begin
        len_a = last_r; now_nxt = high_r + 1'b1;
        state_nxt = sab_pkg::S_AP_LEN_W;
      end
      sab_pkg::S_AP_LEN_W: begin
        high_nxt = now_r;
        len_we = 1'b1; len_a = now_r; len_wd = len_rd + 1'b1;
        if (len_rd + 1'b1 > long_r) long_nxt = len_rd + 1'b1;
        p_nxt = {1'b0, last_r};
        state_nxt = sab_pkg::S_AP_INIT;
      end
      sab_pkg::S_AP_INIT: begin
        tr_we = 1'b1; tr_a = slot(now_r, SW'(k_r)); tr_wd = sab_pkg::NONE;
        k_nxt = k_r + 1'b1;
        if (k_r == AW'(sab_pkg::ALPHABET - 1)) begin
          k_nxt = '0; state_nxt = sab_pkg::S_W_RD;
        end
      end
      sab_pkg::S_W_RD: begin
        if (p_r == sab_pkg::NONE) begin
          lnk_we = 1'b1; lnk_a = now_r; lnk_wd = '0;
          state_nxt = sab_pkg::S_FIN;
        end else begin
          tr_a = slot(p_r[NW-1:0], sym_r); lnk_a = p_r[NW-1:0];
          len_a = p_r[NW-1:0];
          state_nxt = sab_pkg::S_W_WAIT;
        end
      end
      sab_pkg::S_W_WAIT: begin
        cv_nxt = tr_rd; plen_nxt = len_rd;
        q_nxt = lnk_rd[NW-1:0];
        node_nxt = lnk_rd[NW-1:0];
        enext_nxt = lnk_rd;  // next link held temporarily
        state_nxt = sab_pkg::S_W_CHK;
      end
      sab_pkg::S_W_CHK: begin
        if (cv_r == sab_pkg::NONE) begin
          tr_we = 1'b1; tr_a = slot(p_r[NW-1:0], sym_r); tr_wd = {1'b0, now_r};
          p_nxt = enext_r; state_nxt = sab_pkg::S_W_RD;
        end else begin
          q_nxt = cv_r[NW-1:0]; len_a = cv_r[NW-1:0];
          state_nxt = sab_pkg::S_Q_WAIT;
        end
        enext_nxt = '0;
      end
      sab_pkg::S_Q_WAIT: begin
        if (plen_r + 1'b1 == len_rd) begin
          lnk_we = 1'b1; lnk_a = now_r; lnk_wd = {1'b0, q_r};
          state_nxt = sab_pkg::S_FIN;
        end else begin
          ne_nxt = high_r + 1'b1; high_nxt = high_r + 1'b1; cl_nxt = 1'b1;
          len_we = 1'b1; len_a = high_r + 1'b1; len_wd = plen_r + 1'b1;
          if (plen_r + 1'b1 > long_r) long_nxt = plen_r + 1'b1;
          state_nxt = sab_pkg::S_CL_RD;
        end
      end
      sab_pkg::S_CL_RD: begin
        tr_a = slot(q_r, SW'(k_r)); state_nxt = sab_pkg::S_CL_WAIT;
      end
      sab_pkg::S_CL_WAIT: begin
        cv_nxt = tr_rd; state_nxt = sab_pkg::S_CL_WR;
      end
      sab_pkg::S_CL_WR: begin
        tr_we = 1'b1; tr_a = slot(ne_r, SW'(k_r)); tr_wd = cv_r;
        k_nxt = k_r + 1'b1; state_nxt = sab_pkg::S_CL_RD;
        if (k_r == AW'(sab_pkg::ALPHABET - 1)) begin
          k_nxt = '0; lnk_a = q_r; state_nxt = sab_pkg::S_CL_LNK;
        end
      end
      sab_pkg::S_CL_LNK: begin
        lnk_we = 1'b1; lnk_a = ne_r; lnk_wd = lnk_rd;
        state_nxt = sab_pkg::S_R_RD;
      end
      sab_pkg::S_R_RD: begin
        if (p_r == sab_pkg::NONE) begin
          state_nxt = sab_pkg::S_R_CHK; cv_nxt = sab_pkg::NONE;
        end else begin
          tr_a = slot(p_r[NW-1:0], sym_r); lnk_a = p_r[NW-1:0];
          state_nxt = sab_pkg::S_R_WAIT;
        end
      end
      sab_pkg::S_R_WAIT: begin
        cv_nxt = tr_rd; enext_nxt = lnk_rd; state_nxt = sab_pkg::S_R_CHK;
      end
      sab_pkg::S_R_CHK: begin
        if (p_r != sab_pkg::NONE && cv_r == {1'b0, q_r}) begin
          tr_we = 1'b1; tr_a = slot(p_r[NW-1:0], sym_r); tr_wd = {1'b0, ne_r};
          p_nxt = enext_r; state_nxt = sab_pkg::S_R_RD;
        end else begin
          lnk_we = 1'b1; lnk_a = q_r; lnk_wd = {1'b0, ne_r};
          state_nxt = sab_pkg::S_Q_RD;  // then link the new node
        end
        enext_nxt = '0;
      end
      sab_pkg::S_Q_RD: begin
        lnk_we = 1'b1; lnk_a = now_r; lnk_wd = {1'b0, ne_r};
        state_nxt = sab_pkg::S_FIN;
      end
      sab_pkg::S_Q_CHK: state_nxt = sab_pkg::S_FIN;
      sab_pkg::S_FIN: begin
        last_nxt = now_r; state_nxt = sab_pkg::S_OUT;
      end
      sab_pkg::S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; state_nxt = sab_pkg::S_IDLE;
        end
      end
      default: state_nxt = sab_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* bench/suffix_automaton_builder_tb.sv */
// ----------------------------------------------------------------------------
// suffix_automaton_builder_tb: self-checking bench for the automaton builder
// Drives append, read, clear and no-op words with random gaps and sink
// stalls. A behavioral copy of the automaton predicts every result word,
// and each one is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module suffix_automaton_builder_tb;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int         IDLE_LIMIT = 50000;

  typedef struct packed {
    logic [11:0] entry_next;
    logic [11:0] entry_link;
    logic [10:0] entry_length;
    logic        cloned;
    logic [10:0] new_node;
    logic [10:0] longest;
    logic [11:0] node_count;
    logic [1:0]  status;
  } sa_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // symbol[4:0], node[15:5]
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // status, node_count, longest, new_node, cloned,
                           // entry_length, entry_link, entry_next

  suffix_automaton_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // automaton mirror
  int len_tab  [sab_pkg::NODE_CAP];
  int link_tab [sab_pkg::NODE_CAP];
  int next_tab [sab_pkg::TDEPTH];
  int last_nd, high_nd, longest_len;

  sa_result_t pending_results[$];
  int  fail_count;
  int  words_sent, results_seen, appends_ok, clones_seen, fulls_seen, reads_seen;
  int  idle_cycles;
  bit  quiet_src;   // no source gaps
  bit  quiet_sink;  // no sink stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_automaton();
    last_nd     = 0;
    high_nd     = 0;
    longest_len = 0;
    len_tab[0]  = 0;
    link_tab[0] = -1;
    for (int c = 0; c < sab_pkg::ALPHABET; c++) next_tab[c] = -1;
  endfunction

  function automatic sa_result_t predict_word(logic [1:0] kind, int sym, int nd);
    sa_result_t r;
    int now, p, q, ne;
    r = '0;
    if (kind == sab_pkg::KIND_APPEND) begin
      if (sym >= sab_pkg::ALPHABET) begin
        r.status = sab_pkg::ST_RANGE;
      end else if (longest_len >= sab_pkg::MAX_TEXT ||
                   high_nd + 2 >= sab_pkg::NODE_CAP) begin
        r.status = sab_pkg::ST_FULL;
      end else begin
        now = ++high_nd;
        len_tab[now] = len_tab[last_nd] + 1;
        if (len_tab[now] > longest_len) longest_len = len_tab[now];
        for (int c = 0; c < sab_pkg::ALPHABET; c++)
          next_tab[now*sab_pkg::ALPHABET + c] = -1;
        p = last_nd;
        while (p != -1 && next_tab[p*sab_pkg::ALPHABET + sym] == -1) begin
          next_tab[p*sab_pkg::ALPHABET + sym] = now;
          p = link_tab[p];
        end
        if (p == -1) begin
          link_tab[now] = 0;
        end else begin
          q = next_tab[p*sab_pkg::ALPHABET + sym];
          if (len_tab[p] + 1 == len_tab[q]) begin
            link_tab[now] = q;
          end else begin
            ne = ++high_nd;
            r.cloned = 1'b1;
            len_tab[ne] = len_tab[p] + 1;
            if (len_tab[ne] > longest_len) longest_len = len_tab[ne];
            for (int c = 0; c < sab_pkg::ALPHABET; c++)
              next_tab[ne*sab_pkg::ALPHABET + c] = next_tab[q*sab_pkg::ALPHABET + c];
            link_tab[ne] = link_tab[q];
            while (p != -1 && next_tab[p*sab_pkg::ALPHABET + sym] == q) begin
              next_tab[p*sab_pkg::ALPHABET + sym] = ne;
              p = link_tab[p];
            end
            link_tab[q]   = ne;
            link_tab[now] = ne;
          end
        end
        last_nd    = now;
        r.new_node = 11'(now);
      end
    end else if (kind == sab_pkg::KIND_READ) begin
      if (nd > high_nd) begin
        r.status     = sab_pkg::ST_RANGE;
        r.entry_link = '1;
        r.entry_next = '1;
      end else begin
        r.entry_length = 11'(len_tab[nd]);
        r.entry_link   = 12'(link_tab[nd]);
        r.entry_next   = (sym < sab_pkg::ALPHABET) ?
                         12'(next_tab[nd*sab_pkg::ALPHABET + sym]) : 12'hFFF;
      end
    end else if (kind == sab_pkg::KIND_CLEAR) begin
      clear_automaton();
    end
    r.node_count = 12'(high_nd + 1);
    r.longest    = 11'(longest_len);
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one word on the input channel; valid stays high into the next call
  task automatic send_word(logic [1:0] kind, int sym, int nd);
    int gap;
    sa_result_t r;
    gap = pick_gap(quiet_src);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {nd[10:0], sym[4:0]};
    do @(posedge clk); while (!in_tready);
    r = predict_word(kind, sym, nd);
    pending_results.push_back(r);
    words_sent++;
    if (kind == sab_pkg::KIND_APPEND && r.status == sab_pkg::ST_OK) appends_ok++;
    if (r.cloned) clones_seen++;
    if (r.status == sab_pkg::ST_FULL) fulls_seen++;
    if (kind == sab_pkg::KIND_READ) reads_seen++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic read_all_nodes(int sym);
    for (int n = 0; n <= high_nd; n++) send_word(sab_pkg::KIND_READ, sym, n);
  endtask

  // sink side
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pick_gap(quiet_sink);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic check_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    sa_result_t got, exp_r;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("suffix_automaton_builder_tb failed");
        $finish;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status",       exp_r.status,       got.status);
        check_field("node_count",   exp_r.node_count,   got.node_count);
        check_field("longest",      exp_r.longest,      got.longest);
        check_field("new_node",     exp_r.new_node,     got.new_node);
        check_field("cloned",       exp_r.cloned,       got.cloned);
        check_field("entry_length", exp_r.entry_length, got.entry_length);
        check_field("entry_link",   exp_r.entry_link,   got.entry_link);
        check_field("entry_next",   exp_r.entry_next,   got.entry_next);
      end
    end
  end

  // empty automaton, out-of-range operands, no-op
  task automatic test_empty_automaton();
    send_word(sab_pkg::KIND_READ, 0, 0);
    send_word(sab_pkg::KIND_READ, 25, 0);
    send_word(sab_pkg::KIND_READ, 26, 0);
    send_word(sab_pkg::KIND_READ, 31, 0);
    send_word(sab_pkg::KIND_READ, 0, 1);
    send_word(sab_pkg::KIND_READ, 31, 2047);
    send_word(KIND_NOP, 31, 2047);
    send_word(sab_pkg::KIND_APPEND, 26, 0);
    send_word(sab_pkg::KIND_APPEND, 31, 2047);
  endtask

  // "abcbc" forces a clone; then dump the table and clear
  task automatic test_clone_text();
    int txt[5] = '{0, 1, 2, 1, 2};
    foreach (txt[i]) send_word(sab_pkg::KIND_APPEND, txt[i], 0);
    send_word(sab_pkg::KIND_APPEND, 25, 0);
    read_all_nodes(2);
    send_word(sab_pkg::KIND_READ, 1, 1);
    send_word(sab_pkg::KIND_CLEAR, 0, 0);
    send_word(sab_pkg::KIND_READ, 0, 0);
  endtask

  // fill to capacity, hit full, then clear
  task automatic test_fill_to_capacity();
    int n;
    quiet_src = 1'b1;
    n = 0;
    while (longest_len < sab_pkg::MAX_TEXT && high_nd + 2 < sab_pkg::NODE_CAP &&
           n < 1200) begin
      send_word(sab_pkg::KIND_APPEND, $urandom_range(0, 1), 0);
      n++;
    end
    quiet_src = 1'b0;
    send_word(sab_pkg::KIND_APPEND, 0, 0);
    send_word(sab_pkg::KIND_APPEND, 25, 0);
    send_word(sab_pkg::KIND_READ, 1, high_nd);
    send_word(sab_pkg::KIND_READ, 0, 2047);
    send_word(sab_pkg::KIND_READ, 31, $urandom_range(0, high_nd));
    wait_drained();
    send_word(sab_pkg::KIND_CLEAR, 0, 0);
  endtask

  // mixed random traffic, small alphabets so clones are frequent
  task automatic test_random_traffic(int count);
    int roll, sym, nd, alpha;
    alpha = 4;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      quiet_sink = (i >= count / 4 && i < count / 3);
      if (i % 60 == 0) alpha = $urandom_range(2, sab_pkg::ALPHABET);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        sym = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, alpha - 1);
        send_word(sab_pkg::KIND_APPEND, sym, $urandom_range(0, 2047));
      end else if (roll < 88) begin
        nd  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                          : $urandom_range(0, high_nd);
        sym = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                          : $urandom_range(0, alpha - 1);
        send_word(sab_pkg::KIND_READ, sym, nd);
      end else if (roll < 92) begin
        send_word(sab_pkg::KIND_CLEAR, $urandom_range(0, 31), $urandom_range(0, 2047));
      end else begin
        send_word(KIND_NOP, $urandom_range(0, 31), $urandom_range(0, 2047));
      end
    end
    quiet_sink = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = KIND_NOP;
    quiet_src   = 1'b0;
    quiet_sink  = 1'b0;
    fail_count  = 0;
    words_sent  = 0;
    results_seen = 0;
    appends_ok  = 0;
    clones_seen = 0;
    fulls_seen  = 0;
    reads_seen  = 0;
    idle_cycles = 0;
    clear_automaton();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_automaton();
    test_clone_text();
    test_fill_to_capacity();
    test_random_traffic(340);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("words sent %0d, results checked %0d, appends %0d, clones %0d",
             words_sent, results_seen, appends_ok, clones_seen);
    $display("full rejections %0d, reads %0d", fulls_seen, reads_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("suffix_automaton_builder_tb passed");
    end else begin
      $display("suffix_automaton_builder_tb failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/sab_pkg.sv
hdl/sab_ram.sv
hdl/suffix_automaton_builder.sv
bench/suffix_automaton_builder_tb.sv
